>>> rtl/fskc_pkg.sv
// shared types, constants and tables of the feed-forward soft-knee compressor
// depends on nothing; imported by every module of the block

package fskc_pkg;

  localparam int CHANNELS = 2;

  localparam int SAMPLE_W = 24;
  localparam int ENV_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RATIO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KNEE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RMS_MODE  = 3'd6;
  // index past the register list, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  // datapath operations
  localparam int OP_W = 6;
  localparam logic [OP_W-1:0] OP_NONE     = 6'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 6'd1;
  localparam logic [OP_W-1:0] OP_BYP      = 6'd2;
  localparam logic [OP_W-1:0] OP_PK_A     = 6'd3;
  localparam logic [OP_W-1:0] OP_PK_B     = 6'd4;
  localparam logic [OP_W-1:0] OP_PK_C     = 6'd5;
  localparam logic [OP_W-1:0] OP_RM_A     = 6'd6;
  localparam logic [OP_W-1:0] OP_RM_B     = 6'd7;
  localparam logic [OP_W-1:0] OP_RM_C     = 6'd8;
  localparam logic [OP_W-1:0] OP_RM_D     = 6'd9;
  localparam logic [OP_W-1:0] OP_RM_E     = 6'd10;
  localparam logic [OP_W-1:0] OP_RM_F     = 6'd11;
  localparam logic [OP_W-1:0] OP_RM_G     = 6'd12;
  localparam logic [OP_W-1:0] OP_SQ_STEP  = 6'd13;
  localparam logic [OP_W-1:0] OP_SQ_FIN   = 6'd14;
  localparam logic [OP_W-1:0] OP_NM_STEP  = 6'd15;
  localparam logic [OP_W-1:0] OP_LG_A     = 6'd16;
  localparam logic [OP_W-1:0] OP_LG_B     = 6'd17;
  localparam logic [OP_W-1:0] OP_LG_C     = 6'd18;
  localparam logic [OP_W-1:0] OP_LG_D     = 6'd19;
  localparam logic [OP_W-1:0] OP_GN_ZERO  = 6'd20;
  localparam logic [OP_W-1:0] OP_GN_LIN_A = 6'd21;
  localparam logic [OP_W-1:0] OP_GN_LIN_B = 6'd22;
  localparam logic [OP_W-1:0] OP_KN_A     = 6'd23;
  localparam logic [OP_W-1:0] OP_KN_B     = 6'd24;
  localparam logic [OP_W-1:0] OP_KN_C     = 6'd25;
  localparam logic [OP_W-1:0] OP_DV_STEP  = 6'd26;
  localparam logic [OP_W-1:0] OP_DV_FIN   = 6'd27;
  localparam logic [OP_W-1:0] OP_EX_A     = 6'd28;
  localparam logic [OP_W-1:0] OP_EX_B     = 6'd29;
  localparam logic [OP_W-1:0] OP_EX_C     = 6'd30;
  localparam logic [OP_W-1:0] OP_EX_D     = 6'd31;
  localparam logic [OP_W-1:0] OP_EX_E     = 6'd32;
  localparam logic [OP_W-1:0] OP_EX_F     = 6'd33;
  localparam logic [OP_W-1:0] OP_EX_G     = 6'd34;
  localparam logic [OP_W-1:0] OP_OUT      = 6'd35;

  // gain computer regions
  localparam logic [1:0] REG_ZERO = 2'd0;
  localparam logic [1:0] REG_LIN  = 2'd1;
  localparam logic [1:0] REG_KNEE = 2'd2;

  typedef struct packed {
    logic signed [14:0] threshold;
    logic        [16:0] inverse_ratio;
    logic        [15:0] attack_coef;
    logic        [15:0] release_coef;
    logic signed [13:0] makeup_gain;
    logic        [12:0] knee_db;
    logic               rms_mode;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [4:0]      step;
  } cmd_t;

  typedef struct packed {
    logic       bypass;
    logic       rms;
    logic       out_free;
    logic [1:0] region;
  } status_t;

  function automatic logic [16:0] log2_at(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd5732;
      5'd2:  v = 17'd11136;
      5'd3:  v = 17'd16248;
      5'd4:  v = 17'd21098;
      5'd5:  v = 17'd25711;
      5'd6:  v = 17'd30109;
      5'd7:  v = 17'd34312;
      5'd8:  v = 17'd38336;
      5'd9:  v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  function automatic logic [17:0] exp2_at(input logic [4:0] i);
    logic [17:0] v;
    case (i)
      5'd0:  v = 18'd65536;
      5'd1:  v = 18'd68438;
      5'd2:  v = 18'd71468;
      5'd3:  v = 18'd74632;
      5'd4:  v = 18'd77936;
      5'd5:  v = 18'd81386;
      5'd6:  v = 18'd84990;
      5'd7:  v = 18'd88752;
      5'd8:  v = 18'd92682;
      5'd9:  v = 18'd96785;
      5'd10: v = 18'd101070;
      5'd11: v = 18'd105545;
      5'd12: v = 18'd110218;
      5'd13: v = 18'd115136;
      5'd14: v = 18'd120194;
      5'd15: v = 18'd125515;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/feedforward_soft_knee_compressor_top.sv
// top level of the feed-forward soft-knee compressor: ports, configuration
// registers and checks; depends on fskc_pkg, fskc_ctrl and fskc_dp
//
//   channel  direction  payload                               transfer when
//   s_*      in         tdata[23:0] sample_in, tuser[0] ch     s_tvalid & s_tready
//   m_*      out        tdata[23:0] sample_out                 m_tvalid & m_tready
//   cfg_*    in         cfg_index[2:0], cfg_data[16:0]         cfg_valid & cfg_ready
//
// one sample at a time: a new sample is taken only once the last is through;
//   rms mode adds a 24-step square root and the soft knee a 12-step divider
// all steps share one 31 x 25 multiplier with a registered product
// the output register holds a result while the next sample is taken in
// a stalled output only delays acceptance once the next result is ready
// reset clears both envelopes and loads the default register values

module feedforward_soft_knee_compressor_top import fskc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,   // [23:0] sample_in
  input  logic [0:0]            s_tuser,   // [0] channel
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [SAMPLE_W-1:0]   m_tdata,   // [23:0] sample_out
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold     <= -15'sd4608;
      cfg.inverse_ratio <= 17'd16384;
      cfg.attack_coef   <= 16'd65263;
      cfg.release_coef  <= 16'd65519;
      cfg.makeup_gain   <= 14'sd0;
      cfg.knee_db       <= 13'd1536;
      cfg.rms_mode      <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESHOLD: cfg.threshold     <= $signed(cfg_data[14:0]);
        CFG_INV_RATIO: cfg.inverse_ratio <= cfg_data;
        CFG_ATTACK:    cfg.attack_coef   <= cfg_data[15:0];
        CFG_RELEASE:   cfg.release_coef  <= cfg_data[15:0];
        CFG_MAKEUP:    cfg.makeup_gain   <= $signed(cfg_data[13:0]);
        CFG_KNEE:      cfg.knee_db       <= cfg_data[12:0];
        CFG_RMS_MODE:  cfg.rms_mode      <= cfg_data[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // sequencer
  fskc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and storage
  fskc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .cfg      (cfg),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef NO_ASSERTIONS
  // a sample is worked on alone: no second transfer straight after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a sample is in work");

  // the datapath loads a sample only on an input transfer
  a_load_on_transfer: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_LOAD |-> s_tvalid && s_tready)
    else $error("sample load without transfer");

  // a fresh result leaves the sequencer idle again
  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("sequencer busy after result");
`endif

endmodule

>>> rtl/fskc_ctrl.sv
// sequencing state machine of the compressor
// depends on fskc_pkg; drives fskc_dp through cmd_t and reads status_t

module fskc_ctrl import fskc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [5:0] S_IDLE     = 6'd0;
  localparam logic [5:0] S_BYP      = 6'd1;
  localparam logic [5:0] S_PK_A     = 6'd2;
  localparam logic [5:0] S_PK_B     = 6'd3;
  localparam logic [5:0] S_PK_C     = 6'd4;
  localparam logic [5:0] S_RM_A     = 6'd5;
  localparam logic [5:0] S_RM_B     = 6'd6;
  localparam logic [5:0] S_RM_C     = 6'd7;
  localparam logic [5:0] S_RM_D     = 6'd8;
  localparam logic [5:0] S_RM_E     = 6'd9;
  localparam logic [5:0] S_RM_F     = 6'd10;
  localparam logic [5:0] S_RM_G     = 6'd11;
  localparam logic [5:0] S_SQ_STEP  = 6'd12;
  localparam logic [5:0] S_SQ_FIN   = 6'd13;
  localparam logic [5:0] S_NM_STEP  = 6'd14;
  localparam logic [5:0] S_LG_A     = 6'd15;
  localparam logic [5:0] S_LG_B     = 6'd16;
  localparam logic [5:0] S_LG_C     = 6'd17;
  localparam logic [5:0] S_LG_D     = 6'd18;
  localparam logic [5:0] S_GN_SEL   = 6'd19;
  localparam logic [5:0] S_GN_LIN_B = 6'd20;
  localparam logic [5:0] S_KN_B     = 6'd21;
  localparam logic [5:0] S_KN_C     = 6'd22;
  localparam logic [5:0] S_DV_STEP  = 6'd23;
  localparam logic [5:0] S_DV_FIN   = 6'd24;
  localparam logic [5:0] S_EX_A     = 6'd25;
  localparam logic [5:0] S_EX_B     = 6'd26;
  localparam logic [5:0] S_EX_C     = 6'd27;
  localparam logic [5:0] S_EX_D     = 6'd28;
  localparam logic [5:0] S_EX_E     = 6'd29;
  localparam logic [5:0] S_EX_F     = 6'd30;
  localparam logic [5:0] S_EX_G     = 6'd31;
  localparam logic [5:0] S_OUT      = 6'd32;

  logic [5:0] state, state_next;
  logic [4:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = OP_NONE;
    cmd.step   = cnt;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op = OP_LOAD;
          if (status.bypass) state_next = S_BYP;
          else if (status.rms) state_next = S_RM_A;
          else state_next = S_PK_A;
        end
      end
      S_BYP:  begin cmd.op = OP_BYP;  state_next = S_OUT;  end
      S_PK_A: begin cmd.op = OP_PK_A; state_next = S_PK_B; end
      S_PK_B: begin cmd.op = OP_PK_B; state_next = S_PK_C; end
      S_PK_C: begin
        cmd.op = OP_PK_C;
        state_next = S_NM_STEP;
        cnt_next = 5'd4;
      end
      S_RM_A: begin cmd.op = OP_RM_A; state_next = S_RM_B; end
      S_RM_B: begin cmd.op = OP_RM_B; state_next = S_RM_C; end
      S_RM_C: begin cmd.op = OP_RM_C; state_next = S_RM_D; end
      S_RM_D: begin cmd.op = OP_RM_D; state_next = S_RM_E; end
      S_RM_E: begin cmd.op = OP_RM_E; state_next = S_RM_F; end
      S_RM_F: begin cmd.op = OP_RM_F; state_next = S_RM_G; end
      S_RM_G: begin
        cmd.op = OP_RM_G;
        state_next = S_SQ_STEP;
        cnt_next = 5'd23;
      end
      S_SQ_STEP: begin
        cmd.op = OP_SQ_STEP;
        if (cnt == 5'd0) state_next = S_SQ_FIN;
        else cnt_next = cnt - 5'd1;
      end
      S_SQ_FIN: begin
        cmd.op = OP_SQ_FIN;
        state_next = S_NM_STEP;
        cnt_next = 5'd4;
      end
      S_NM_STEP: begin
        cmd.op = OP_NM_STEP;
        if (cnt == 5'd0) state_next = S_LG_A;
        else cnt_next = cnt - 5'd1;
      end
      S_LG_A: begin cmd.op = OP_LG_A; state_next = S_LG_B; end
      S_LG_B: begin cmd.op = OP_LG_B; state_next = S_LG_C; end
      S_LG_C: begin cmd.op = OP_LG_C; state_next = S_LG_D; end
      S_LG_D: begin cmd.op = OP_LG_D; state_next = S_GN_SEL; end
      S_GN_SEL: begin
        unique case (status.region)
          REG_ZERO: begin cmd.op = OP_GN_ZERO;  state_next = S_EX_A;     end
          REG_LIN:  begin cmd.op = OP_GN_LIN_A; state_next = S_GN_LIN_B; end
          default:  begin cmd.op = OP_KN_A;     state_next = S_KN_B;     end
        endcase
      end
      S_GN_LIN_B: begin cmd.op = OP_GN_LIN_B; state_next = S_EX_A; end
      S_KN_B: begin cmd.op = OP_KN_B; state_next = S_KN_C; end
      S_KN_C: begin
        cmd.op = OP_KN_C;
        state_next = S_DV_STEP;
        cnt_next = 5'd11;
      end
      S_DV_STEP: begin
        cmd.op = OP_DV_STEP;
        if (cnt == 5'd0) state_next = S_DV_FIN;
        else cnt_next = cnt - 5'd1;
      end
      S_DV_FIN: begin cmd.op = OP_DV_FIN; state_next = S_EX_A; end
      S_EX_A: begin cmd.op = OP_EX_A; state_next = S_EX_B; end
      S_EX_B: begin cmd.op = OP_EX_B; state_next = S_EX_C; end
      S_EX_C: begin cmd.op = OP_EX_C; state_next = S_EX_D; end
      S_EX_D: begin cmd.op = OP_EX_D; state_next = S_EX_E; end
      S_EX_E: begin cmd.op = OP_EX_E; state_next = S_EX_F; end
      S_EX_F: begin cmd.op = OP_EX_F; state_next = S_EX_G; end
      S_EX_G: begin cmd.op = OP_EX_G; state_next = S_OUT;  end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/fskc_dp.sv
// datapath of the compressor: envelope store, shared multiplier, root,
// normaliser, divider and output register; depends on fskc_pkg

module fskc_dp import fskc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  cfg_t                cfg,
  input  logic [SAMPLE_W-1:0] s_tdata,
  input  logic [0:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata
);

  localparam logic signed [16:0] DB_FLOOR = -17'sd61440;

  logic [ENV_W-1:0] env [CHANNELS];

  logic signed [23:0] x_r;
  logic [0:0]         ch_r;
  logic [23:0]        level, prev;
  logic [15:0]        c;
  logic [16:0]        cc;

  logic signed [30:0] ma;
  logic signed [24:0] mb;
  logic signed [55:0] prod;

  logic [47:0] p2, s2;
  logic [63:0] acc;
  logic [47:0] v, r, sqb;
  logic [23:0] nv;
  logic [4:0]  k;
  logic        lvl_zero;
  logic signed [22:0] lg;
  logic signed [18:0] d;
  logic [47:0] rem, dsh;
  logic [11:0] q;
  logic signed [18:0] g;
  logic [15:0] ef;
  logic [5:0]  sh;
  logic [17:0] mant;
  logic signed [57:0] t;
  logic [23:0] yres;

  // input side
  logic [23:0] level_in;
  logic [15:0] c_in;
  always_comb begin
    level_in = s_tdata[23] ? (~s_tdata + 24'd1) : s_tdata;
    c_in = (level_in > env[s_tuser]) ? cfg.attack_coef : cfg.release_coef;
  end

  // gain computer terms
  logic [16:0]        rc;
  logic signed [17:0] rm;
  logic [16:0]        cr;
  logic signed [19:0] d2, ks, u_full;
  logic [14:0]        u;
  logic [1:0]         region;
  always_comb begin
    rc = (cfg.inverse_ratio > 17'd65536) ? 17'd65536 : cfg.inverse_ratio;
    rm = $signed({1'b0, rc}) - 18'sd65536;
    cr = 17'd65536 - rc;
    d2 = $signed({d, 1'b0});
    ks = $signed({7'b0, cfg.knee_db});
    u_full = d2 + ks;
    u = u_full[14:0];
    if (cfg.knee_db == 13'd0) begin
      region = (d <= 19'sd0) ? REG_ZERO : REG_LIN;
    end else if (d2 < -ks) begin
      region = REG_ZERO;
    end else if (d2 > ks) begin
      region = REG_LIN;
    end else begin
      region = REG_KNEE;
    end
  end

  always_comb begin
    status.bypass   = ({31'b0, s_tuser} >= 32'(CHANNELS));
    status.rms      = cfg.rms_mode;
    status.out_free = !m_tvalid || m_tready;
    status.region   = region;
  end

  // table slopes
  logic [16:0] lg_diff;
  logic [17:0] ex_diff;
  always_comb begin
    lg_diff = log2_at({1'b0, nv[22:19]} + 5'd1) - log2_at({1'b0, nv[22:19]});
    ex_diff = exp2_at({1'b0, ef[15:12]} + 5'd1) - exp2_at({1'b0, ef[15:12]});
  end

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_PK_A:     begin ma = $signed({7'b0, prev});  mb = $signed({9'b0, c});  end
      OP_PK_B:     begin ma = $signed({7'b0, level}); mb = $signed({8'b0, cc}); end
      OP_RM_A:     begin ma = $signed({7'b0, prev});  mb = $signed({1'b0, prev}); end
      OP_RM_B:     begin ma = $signed({7'b0, level}); mb = $signed({1'b0, level}); end
      OP_RM_C:     begin ma = $signed({7'b0, p2[23:0]});  mb = $signed({9'b0, c}); end
      OP_RM_D:     begin ma = $signed({7'b0, p2[47:24]}); mb = $signed({9'b0, c}); end
      OP_RM_E:     begin ma = $signed({7'b0, s2[23:0]});  mb = $signed({8'b0, cc}); end
      OP_RM_F:     begin ma = $signed({7'b0, s2[47:24]}); mb = $signed({8'b0, cc}); end
      OP_LG_A:     begin ma = $signed({19'b0, nv[18:7]}); mb = $signed({8'b0, lg_diff}); end
      OP_LG_C:     begin ma = {{8{lg[22]}}, lg}; mb = 25'sd24660; end
      OP_GN_LIN_A: begin ma = {{12{d[18]}}, d}; mb = {{7{rm[17]}}, rm}; end
      OP_KN_A:     begin ma = $signed({16'b0, u}); mb = $signed({10'b0, u}); end
      OP_KN_B:     begin ma = $signed({1'b0, prod[29:0]}); mb = $signed({8'b0, cr}); end
      OP_EX_A:     begin ma = {{12{g[18]}}, g}; mb = 25'sd43541; end
      OP_EX_C:     begin ma = $signed({19'b0, ef[11:0]}); mb = $signed({7'b0, ex_diff}); end
      OP_EX_E:     begin ma = {{7{x_r[23]}}, x_r}; mb = $signed({7'b0, mant}); end
      default:     begin ma = '0; mb = '0; end
    endcase
  end

  // helper terms for the register updates
  logic [63:0]        prod_u;
  logic [63:0]        pk_sum, rm_sum;
  logic [47:0]        sq_trial;
  logic signed [55:0] db_full, gl_full, ex_full;
  logic signed [16:0] dbv;
  logic signed [23:0] e_next;
  logic signed [7:0]  n_raw, n_cl;
  logic signed [7:0]  sh_full;
  logic [55:0]        rnd12;
  logic signed [5:0]  kk;
  logic signed [57:0] ys;
  logic [23:0]        ysat;
  always_comb begin
    prod_u   = {8'b0, prod};
    pk_sum   = acc + prod_u;
    rm_sum   = acc + (prod_u << 24);
    sq_trial = r + sqb;
    db_full  = (prod + 56'sd524288) >>> 20;
    dbv      = lvl_zero ? DB_FLOOR : db_full[16:0];
    gl_full  = (prod + 56'sd32768) >>> 16;
    ex_full  = (prod + 56'sd512) >>> 10;
    e_next   = ex_full[23:0];
    n_raw    = e_next[23:16];
    if (n_raw > 8'sd15) n_cl = 8'sd15;
    else if (n_raw < -8'sd40) n_cl = -8'sd40;
    else n_cl = n_raw;
    sh_full  = 8'sd16 - n_cl;
    rnd12    = (prod + 56'sd2048) >>> 12;
    kk       = $signed({1'b0, k}) - 6'sd23;
    ys       = t >>> sh;
    if (ys > 58'sd8388607) ysat = 24'h7FFFFF;
    else if (ys < -58'sd8388608) ysat = 24'h800000;
    else ysat = ys[23:0];
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // envelope store and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) env[i] <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.op == OP_PK_C) env[ch_r] <= pk_sum[39:16];
      if (cmd.op == OP_SQ_FIN) env[ch_r] <= r[23:0];
      if (cmd.op == OP_OUT) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x_r   <= $signed(s_tdata);
        ch_r  <= s_tuser;
        level <= level_in;
        prev  <= env[s_tuser];
        c     <= c_in;
        cc    <= 17'd65536 - {1'b0, c_in};
      end
      OP_BYP: yres <= x_r;
      OP_PK_B: acc <= prod_u + 64'd32768;
      OP_PK_C: begin
        nv <= pk_sum[39:16];
        k <= 5'd23;
        lvl_zero <= (pk_sum[39:16] == 24'd0);
      end
      OP_RM_B: p2 <= prod[47:0];
      OP_RM_C: s2 <= prod[47:0];
      OP_RM_D: acc <= prod_u + 64'd32768;
      OP_RM_E: acc <= rm_sum;
      OP_RM_F: acc <= pk_sum;
      OP_RM_G: begin
        v   <= rm_sum[63:16];
        r   <= '0;
        sqb <= 48'd1 << 46;
      end
      OP_SQ_STEP: begin
        if (v >= sq_trial) begin
          v <= v - sq_trial;
          r <= (r >> 1) + sqb;
        end else begin
          r <= r >> 1;
        end
        sqb <= sqb >> 2;
      end
      OP_SQ_FIN: begin
        nv <= r[23:0];
        k <= 5'd23;
        lvl_zero <= (r[23:0] == 24'd0);
      end
      OP_NM_STEP: begin
        // binary search for the leading one, widest step first
        case (cmd.step[2:0])
          3'd4: if (nv[23:8] == 16'd0) begin nv <= {nv[7:0], 16'b0}; k <= k - 5'd16; end
          3'd3: if (nv[23:16] == 8'd0) begin nv <= {nv[15:0], 8'b0}; k <= k - 5'd8; end
          3'd2: if (nv[23:20] == 4'd0) begin nv <= {nv[19:0], 4'b0}; k <= k - 5'd4; end
          3'd1: if (nv[23:22] == 2'd0) begin nv <= {nv[21:0], 2'b0}; k <= k - 5'd2; end
          3'd0: if (!nv[23]) begin nv <= {nv[22:0], 1'b0}; k <= k - 5'd1; end
          default: ;
        endcase
      end
      OP_LG_B: lg <= {kk[5], kk, 16'b0} +
                     {5'b0, {1'b0, log2_at({1'b0, nv[22:19]})} + rnd12[17:0]};
      OP_LG_D: d <= {{2{dbv[16]}}, dbv} - {{4{cfg.threshold[14]}}, cfg.threshold};
      OP_GN_ZERO: g <= {{5{cfg.makeup_gain[13]}}, cfg.makeup_gain};
      OP_GN_LIN_B: g <= gl_full[18:0] + {{5{cfg.makeup_gain[13]}}, cfg.makeup_gain};
      OP_KN_C: begin
        rem <= prod[47:0] + {16'b0, cfg.knee_db, 19'b0};
        dsh <= {4'b0, cfg.knee_db, 31'b0};
        q   <= '0;
      end
      OP_DV_STEP: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          q <= {q[10:0], 1'b1};
        end else begin
          q <= {q[10:0], 1'b0};
        end
        dsh <= dsh >> 1;
      end
      OP_DV_FIN: g <= {{5{cfg.makeup_gain[13]}}, cfg.makeup_gain} - {7'b0, q};
      OP_EX_B: begin
        ef <= e_next[15:0];
        sh <= sh_full[5:0];
      end
      OP_EX_D: mant <= exp2_at({1'b0, ef[15:12]}) + rnd12[17:0];
      OP_EX_F: t <= {{2{prod[55]}}, prod} + (58'sd1 <<< (sh - 6'd1));
      OP_EX_G: yres <= ysat;
      OP_OUT: m_tdata <= yres;
      default: ;
    endcase
  end

endmodule
